/* hdl/hag_pkg.sv */
// ----------------------------------------------------------------------------
// hag_pkg: shared definitions of the hit accumulation grid
// Grid geometry, field widths, operation and status codes, memory word and
// request types, and the color merge used on repeated hits.
// ----------------------------------------------------------------------------
`default_nettype none

package hag_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COUNT_BITS  = 16;

    localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int LEN_W       = $clog2(CELLS + 1);

    localparam int OPCODE_W    = 2;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int COLOR_W     = 8;
    localparam int TID_W       = 8;
    localparam int INDEX_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int TOTAL_W     = 17;
    localparam int PEAK_W      = 16;
    localparam int OUT_XY_W    = 8;
    localparam int OUT_COUNT_W = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // operation codes; the unused code decodes as a read
    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED         = 3'd0,
        ST_OUT_OF_BOUNDS = 3'd1,
        ST_CLEARED       = 3'd2,
        ST_ENTRY         = 3'd3,
        ST_NO_ENTRY      = 3'd4
    } status_t;

    typedef struct packed {
        logic [COLOR_W-1:0] alpha;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgba_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        rgba_t                 color;
        logic [TID_W-1:0]      tid;
    } pix_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        pix_word_t         data;
    } pix_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] data;
    } list_wr_t;

    typedef struct packed {
        status_t            status;
        logic [TOTAL_W-1:0] total;
        logic [PEAK_W-1:0]  peak;
        logic [OUT_XY_W-1:0] x;
        logic [OUT_XY_W-1:0] y;
        logic [OUT_COUNT_W-1:0] count;
        rgba_t              color;
        logic [TID_W-1:0]   tid;
    } result_t;

    // per-channel truncated mean
    function automatic rgba_t color_mean(rgba_t a, rgba_t b);
        logic [COLOR_W:0] sr;
        logic [COLOR_W:0] sg;
        logic [COLOR_W:0] sb;
        logic [COLOR_W:0] sa;
        rgba_t            m;
        sr = {1'b0, a.red}   + {1'b0, b.red};
        sg = {1'b0, a.green} + {1'b0, b.green};
        sb = {1'b0, a.blue}  + {1'b0, b.blue};
        sa = {1'b0, a.alpha} + {1'b0, b.alpha};
        m.red   = sr[COLOR_W:1];
        m.green = sg[COLOR_W:1];
        m.blue  = sb[COLOR_W:1];
        m.alpha = sa[COLOR_W:1];
        return m;
    endfunction

endpackage

`default_nettype wire

/* hdl/hag_hit_if.sv */
// ----------------------------------------------------------------------------
// hag_hit_if: operation channel of the hit accumulation grid
// One beat carries an opcode with hit position, id, color and list index.
// ----------------------------------------------------------------------------
`default_nettype none

interface hag_hit_if import hag_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic [TID_W-1:0]          transform_id;
    logic [COLOR_W-1:0]        in_red;
    logic [COLOR_W-1:0]        in_green;
    logic [COLOR_W-1:0]        in_blue;
    logic [COLOR_W-1:0]        in_alpha;
    logic [INDEX_W-1:0]        list_index;

    modport source (
        output valid, opcode, hit_x, hit_y, transform_id,
               in_red, in_green, in_blue, in_alpha, list_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, hit_x, hit_y, transform_id,
               in_red, in_green, in_blue, in_alpha, list_index,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/hag_result_if.sv */
// ----------------------------------------------------------------------------
// hag_result_if: result channel of the hit accumulation grid
// One beat carries status, list totals and the fields of a read entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface hag_result_if import hag_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [TOTAL_W-1:0]     touched_total;
    logic [PEAK_W-1:0]      peak_count;
    logic [OUT_XY_W-1:0]    out_x;
    logic [OUT_XY_W-1:0]    out_y;
    logic [OUT_COUNT_W-1:0] out_count;
    logic [COLOR_W-1:0]     out_red;
    logic [COLOR_W-1:0]     out_green;
    logic [COLOR_W-1:0]     out_blue;
    logic [COLOR_W-1:0]     out_alpha;
    logic [TID_W-1:0]       out_transform_id;

    modport source (
        output valid, status, touched_total, peak_count, out_x, out_y, out_count,
               out_red, out_green, out_blue, out_alpha, out_transform_id,
        input  ready
    );

    modport sink (
        input  valid, status, touched_total, peak_count, out_x, out_y, out_count,
               out_red, out_green, out_blue, out_alpha, out_transform_id,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/hag_cfg_if.sv */
// ----------------------------------------------------------------------------
// hag_cfg_if: register write channel of the hit accumulation grid
// One beat writes data to the register selected by index.
// ----------------------------------------------------------------------------
`default_nettype none

interface hag_cfg_if import hag_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_W-1:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

`default_nettype wire

/* hdl/hag_pixel_ram.sv */
// ----------------------------------------------------------------------------
// hag_pixel_ram: per-pixel state memory
// Count, color and id of every grid pixel; one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hag_pixel_ram import hag_pkg::*; (
    input  wire logic    clk,
    input  wire rd_req_t rd,
    output pix_word_t    rd_data,
    input  wire pix_wr_t wr
);

    pix_word_t mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/hag_list_ram.sv */
// ----------------------------------------------------------------------------
// hag_list_ram: touched pixel list
// Grid addresses of first-hit pixels in order of arrival; one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hag_list_ram import hag_pkg::*; (
    input  wire logic         clk,
    input  wire rd_req_t      rd,
    output logic [ADDR_W-1:0] rd_data,
    input  wire list_wr_t     wr
);

    logic [ADDR_W-1:0] mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/hit_accumulation_grid.sv */
// ----------------------------------------------------------------------------
// hit_accumulation_grid: 2D hit accumulation grid
// Counts hits per pixel, merges colors, keeps a list of touched pixels and
// supports clearing and reading back touched entries.
// ----------------------------------------------------------------------------
// Steps: an add hit runs pixel read, update and write back, and result
// register; an out-of-bounds hit goes to the result register directly; a
// read entry runs list read and pixel read first. Clear: one list entry
// swept per cycle. One operation at a time; the next beat is taken in the
// idle state, entered when the previous result is registered.
// Reset: a sweep zeroes all 65536 pixel words, one per cycle, before the
// first beat is taken; register writes are taken during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_accumulation_grid import hag_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hag_cfg_if.sink     cfg,
    hag_hit_if.sink     hit,
    hag_result_if.source result
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HIT,
        S_CLR,
        S_RD_LIST,
        S_RD_PIX,
        S_DONE
    } state_t;

    state_t             state_reg,   state_next;
    logic [CFG_W-1:0]   grid_w_reg;
    logic [CFG_W-1:0]   grid_h_reg;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [COUNT_BITS-1:0] max_reg,  max_next;
    logic [LEN_W-1:0]   ptr_reg,     ptr_next;
    logic               clr_wr_reg,  clr_wr_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic [TID_W-1:0]   tid_reg,     tid_next;
    rgba_t              color_reg,   color_next;
    result_t            pend_reg,    pend_next;
    result_t            res_reg,     res_next;
    logic               res_valid_reg, res_valid_next;

    rd_req_t            pix_rd;
    pix_wr_t            pix_wr;
    pix_word_t          pix_rd_data;
    rd_req_t            list_rd;
    list_wr_t           list_wr;
    logic [ADDR_W-1:0]  list_rd_data;

    logic [COORD_W-1:0] w_eff;
    logic [COORD_W-1:0] h_eff;
    logic               hit_in;
    logic [ADDR_W-1:0]  hit_addr;
    logic [COUNT_BITS-1:0] cnt_new;
    logic               first_hit;

    hag_pixel_ram u_pixel_ram (
        .clk     (clk),
        .rd      (pix_rd),
        .rd_data (pix_rd_data),
        .wr      (pix_wr)
    );

    hag_list_ram u_list_ram (
        .clk     (clk),
        .rd      (list_rd),
        .rd_data (list_rd_data),
        .wr      (list_wr)
    );

    // register file
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= CFG_W'(256);
            grid_h_reg <= CFG_W'(256);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  grid_w_reg <= cfg.data;
                REG_GRID_HEIGHT: grid_h_reg <= cfg.data;
                default:         grid_h_reg <= grid_h_reg;
            endcase
        end
    end

    // bounds check against the clamped grid size
    always_comb
    begin
        w_eff = (COORD_W'(grid_w_reg) > COORD_W'(MAX_WIDTH)) ?
                COORD_W'(MAX_WIDTH) : COORD_W'(grid_w_reg);
        h_eff = (COORD_W'(grid_h_reg) > COORD_W'(MAX_HEIGHT)) ?
                COORD_W'(MAX_HEIGHT) : COORD_W'(grid_h_reg);
        hit_in = !hit.hit_x[COORD_W-1] && !hit.hit_y[COORD_W-1] &&
                 ($unsigned(hit.hit_x) < w_eff) && ($unsigned(hit.hit_y) < h_eff);
        hit_addr = ADDR_W'(ADDR_W'($unsigned(hit.hit_y)) * ADDR_W'(MAX_WIDTH)
                           + ADDR_W'($unsigned(hit.hit_x)));
    end

    assign first_hit = (pix_rd_data.count == '0);
    assign cnt_new   = (pix_rd_data.count != COUNT_MAX) ?
                       pix_rd_data.count + 1'b1 : pix_rd_data.count;

    assign hit.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        max_next       = max_reg;
        ptr_next       = ptr_reg;
        clr_wr_next    = clr_wr_reg;
        addr_next      = addr_reg;
        tid_next       = tid_reg;
        color_next     = color_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        pix_rd         = '0;
        pix_wr         = '0;
        list_rd        = '0;
        list_wr        = '0;

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                pix_wr.en   = 1'b1;
                pix_wr.addr = ptr_reg[ADDR_W-1:0];
                if (ptr_reg == LEN_W'(CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (hit.valid)
                begin
                    addr_next  = hit_addr;
                    tid_next   = hit.transform_id;
                    color_next = '{alpha: hit.in_alpha, blue: hit.in_blue,
                                   green: hit.in_green, red: hit.in_red};
                    pend_next       = '0;
                    pend_next.total = TOTAL_W'(len_reg);
                    pend_next.peak  = PEAK_W'(max_reg);
                    if (hit.opcode == OP_ADD)
                    begin
                        if (hit_in)
                        begin
                            pix_rd.en   = 1'b1;
                            pix_rd.addr = hit_addr;
                            state_next  = S_HIT;
                        end
                        else
                        begin
                            pend_next.status = ST_OUT_OF_BOUNDS;
                            state_next       = S_DONE;
                        end
                    end
                    else if (hit.opcode == OP_CLEAR)
                    begin
                        ptr_next    = '0;
                        clr_wr_next = 1'b0;
                        state_next  = S_CLR;
                    end
                    else if (LEN_W'(hit.list_index) >= len_reg)
                    begin
                        pend_next.status = ST_NO_ENTRY;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        list_rd.en   = 1'b1;
                        list_rd.addr = ADDR_W'(hit.list_index);
                        state_next   = S_RD_LIST;
                    end
                end
            end

            S_HIT:
            begin
                pix_wr.en         = 1'b1;
                pix_wr.addr       = addr_reg;
                pix_wr.data.count = cnt_new;
                pix_wr.data.tid   = tid_reg;
                pix_wr.data.color = first_hit ? color_reg :
                                    color_mean(pix_rd_data.color, color_reg);
                if (cnt_new > max_reg)
                begin
                    max_next = cnt_new;
                end
                // append on first hit while the list has room
                if (first_hit && (len_reg < LEN_W'(CELLS)))
                begin
                    list_wr.en   = 1'b1;
                    list_wr.addr = len_reg[ADDR_W-1:0];
                    list_wr.data = addr_reg;
                    len_next     = len_reg + 1'b1;
                end
                pend_next.status = ST_ADDED;
                pend_next.total  = TOTAL_W'(len_next);
                pend_next.peak   = PEAK_W'(max_next);
                state_next       = S_DONE;
            end

            S_CLR:
            begin
                // list word read last cycle names the pixel to zero now
                if (clr_wr_reg)
                begin
                    pix_wr.en   = 1'b1;
                    pix_wr.addr = list_rd_data;
                end
                if (ptr_reg < len_reg)
                begin
                    list_rd.en   = 1'b1;
                    list_rd.addr = ptr_reg[ADDR_W-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                    clr_wr_next  = 1'b1;
                end
                else
                begin
                    clr_wr_next      = 1'b0;
                    len_next         = '0;
                    max_next         = '0;
                    pend_next.status = ST_CLEARED;
                    pend_next.total  = '0;
                    pend_next.peak   = '0;
                    state_next       = S_DONE;
                end
            end

            S_RD_LIST:
            begin
                pix_rd.en   = 1'b1;
                pix_rd.addr = list_rd_data;
                addr_next   = list_rd_data;
                state_next  = S_RD_PIX;
            end

            S_RD_PIX:
            begin
                pend_next.status = ST_ENTRY;
                pend_next.x      = OUT_XY_W'(addr_reg % MAX_WIDTH);
                pend_next.y      = OUT_XY_W'(addr_reg / MAX_WIDTH);
                pend_next.count  = OUT_COUNT_W'(pix_rd_data.count);
                pend_next.color  = pix_rd_data.color;
                pend_next.tid    = pix_rd_data.tid;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            len_reg       <= '0;
            max_reg       <= '0;
            ptr_reg       <= '0;
            clr_wr_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            max_reg       <= max_next;
            ptr_reg       <= ptr_next;
            clr_wr_reg    <= clr_wr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        tid_reg   <= tid_next;
        color_reg <= color_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.status           = res_reg.status;
    assign result.touched_total    = res_reg.total;
    assign result.peak_count       = res_reg.peak;
    assign result.out_x            = res_reg.x;
    assign result.out_y            = res_reg.y;
    assign result.out_count        = res_reg.count;
    assign result.out_red          = res_reg.color.red;
    assign result.out_green        = res_reg.color.green;
    assign result.out_blue         = res_reg.color.blue;
    assign result.out_alpha        = res_reg.color.alpha;
    assign result.out_transform_id = res_reg.tid;

    // a touched entry always has a nonzero count
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == ST_ENTRY) |-> result.out_count != '0)
        else $error("read entry returned a zero count");

    // an added hit leaves at least one touched pixel
    a_added_total: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == ST_ADDED) |-> result.touched_total != '0)
        else $error("hit added with an empty touched list");

    // one operation at a time
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid && hit.ready |=> !hit.ready)
        else $error("beat taken while an operation is in flight");

    // the list never grows past the grid
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HIT) && (len_reg == LEN_W'(CELLS)) |=> len_reg == LEN_W'(CELLS))
        else $error("touched list grew past the grid size");

endmodule

`default_nettype wire
